/* rtl/ihl_pkg.sv */
// Package: shared types, constants and hex decode for the Intel HEX loader.
package ihl_pkg;

  // Phase of the record parser.
  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_COUNT      = 3'd1,
    PH_ADDRESS    = 3'd2,
    PH_TYPE       = 3'd3,
    PH_DATA       = 3'd4,
    PH_SKIP       = 3'd5,
    PH_STOPPED    = 3'd6
  } ihl_phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_WARN  = 2'd2;

  // Characters and record types.
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  typedef struct packed {
    ihl_phase_t  phase;
    logic [1:0]  nibble_count;
    logic [7:0]  byte_count;
    logic [15:0] record_address;
    logic [7:0]  type_byte;
    logic [7:0]  data_index;
    logic [15:0] partial_value;
    logic [16:0] last_end;
  } ihl_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [16:0] load_end;
    logic [7:0]  record_type;
  } ihl_result_t;

  // Map an ASCII hex digit to its value; anything else reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

endpackage

/* rtl/ihl_if.sv */
// Interfaces: character input channel and result channel.
interface ihl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface ihl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [16:0] load_end;
  logic [7:0]  record_type;

  modport source (output valid, output kind, output write_address, output write_data,
                  output load_end, output record_type, input ready);
  modport sink (input valid, input kind, input write_address, input write_data,
                input load_end, input record_type, output ready);
endinterface

/* rtl/ihl_parse.sv */
// Record parser step: next parser state and optional result for one character.
module ihl_parse #(
  parameter int ADDR_BITS = 16
) (
  input  ihl_pkg::ihl_state_t  state_i,
  input  logic [7:0]           character_i,
  output ihl_pkg::ihl_state_t  state_o,
  output logic                 res_valid_o,
  output ihl_pkg::ihl_result_t res_o
);

  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  logic [15:0] pv;
  logic [1:0]  nc;
  logic [15:0] wr_addr;
  logic [7:0]  idx_inc;

  always_comb begin
    pv      = {state_i.partial_value[11:0], ihl_pkg::hex_nibble(character_i)};
    nc      = state_i.nibble_count + 2'd1;
    wr_addr = (state_i.record_address + {8'd0, state_i.data_index}) & ADDR_MASK;
    idx_inc = state_i.data_index + 8'd1;

    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_i.phase)
      ihl_pkg::PH_STOPPED: begin
        // hold until reset
      end
      ihl_pkg::PH_LINE_START: begin
        if (character_i == ihl_pkg::CH_COLON) begin
          state_o.phase         = ihl_pkg::PH_COUNT;
          state_o.nibble_count  = 2'd0;
          state_o.partial_value = 16'd0;
        end else if (character_i != ihl_pkg::CH_LF) begin
          state_o.phase = ihl_pkg::PH_SKIP;
        end
      end
      default: begin
        priority if (character_i == ihl_pkg::CH_LF) begin
          state_o.phase = ihl_pkg::PH_LINE_START;
        end else if (state_i.phase == ihl_pkg::PH_SKIP) begin
          // drop the rest of the line
        end else if (character_i == ihl_pkg::CH_CR) begin
          state_o.phase = ihl_pkg::PH_SKIP;
        end else begin
          state_o.partial_value = pv;
          state_o.nibble_count  = nc;
          unique case (state_i.phase)
            ihl_pkg::PH_COUNT: begin
              if (nc == 2'd2) begin
                state_o.byte_count    = pv[7:0];
                state_o.phase         = ihl_pkg::PH_ADDRESS;
                state_o.nibble_count  = 2'd0;
                state_o.partial_value = 16'd0;
              end
            end
            ihl_pkg::PH_ADDRESS: begin
              if (nc == 2'd0) begin
                state_o.record_address = pv;
                state_o.phase          = ihl_pkg::PH_TYPE;
                state_o.partial_value  = 16'd0;
              end
            end
            ihl_pkg::PH_TYPE: begin
              if (nc == 2'd2) begin
                state_o.type_byte     = pv[7:0];
                state_o.nibble_count  = 2'd0;
                state_o.partial_value = 16'd0;
                state_o.data_index    = 8'd0;
                res_o.record_type     = pv[7:0];
                res_o.load_end        = state_i.last_end;
                if (pv[7:0] == ihl_pkg::TYPE_DATA) begin
                  state_o.last_end = {1'b0, state_i.record_address}
                                   + {9'd0, state_i.byte_count} + 17'd1;
                  state_o.phase    = (state_i.byte_count == 8'd0) ?
                                     ihl_pkg::PH_SKIP : ihl_pkg::PH_DATA;
                end else if (pv[7:0] == ihl_pkg::TYPE_EOF) begin
                  state_o.phase = ihl_pkg::PH_STOPPED;
                  res_valid_o   = 1'b1;
                  res_o.kind    = ihl_pkg::KIND_END;
                end else begin
                  state_o.phase = ihl_pkg::PH_SKIP;
                  res_valid_o   = 1'b1;
                  res_o.kind    = ihl_pkg::KIND_WARN;
                end
              end
            end
            ihl_pkg::PH_DATA: begin
              if (nc == 2'd2) begin
                state_o.nibble_count  = 2'd0;
                state_o.partial_value = 16'd0;
                state_o.data_index    = idx_inc;
                if (idx_inc >= state_i.byte_count) begin
                  state_o.phase = ihl_pkg::PH_SKIP;
                end
                res_valid_o         = 1'b1;
                res_o.kind          = ihl_pkg::KIND_WRITE;
                res_o.write_address = wr_addr;
                res_o.write_data    = pv[7:0];
                res_o.load_end      = state_i.last_end;
                res_o.record_type   = state_i.type_byte;
              end
            end
            default: begin
              state_o.phase = ihl_pkg::PH_SKIP;
            end
          endcase
        end
      end
    endcase
  end

endmodule

/* rtl/intel_hex_loader.sv */
// Top level: Intel HEX text stream in, memory write / end / warning items out.
//
// Intel HEX loader. Feed the text of a HEX file one character per item on
// in_ch; each data byte of a type 00 record comes out on out_ch as a write
// item (kind 0) at record address plus byte index, wrapped to ADDR_BITS bits,
// carrying the load end (address + count + 1 of the latest data record). A
// type 01 record yields one end item (kind 1) and the block then ignores all
// further characters until reset; any other type yields a warning item
// (kind 2) with the type byte and its body is skipped. Only lines that start
// with ':' are parsed, non-hex digits read as zero, the checksum is ignored,
// and a line feed or carriage return inside a record cuts it short. The
// block takes one character every clock while out_ch does not hold it back:
// an input register holds the character, the parser updates its state in one
// pass, and a result register presents the item. While a result waits
// unclaimed the empty input register still takes one more character, then
// in_ch ready stays low until out_ch ready returns.
module intel_hex_loader #(
  parameter int ADDR_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  ihl_in_if.sink           in_ch,
  ihl_out_if.source        out_ch
);

  logic                 in_valid_r;
  logic [7:0]           in_char_r;
  ihl_pkg::ihl_state_t  state_r;
  ihl_pkg::ihl_state_t  state_nxt;
  logic                 res_valid;
  ihl_pkg::ihl_result_t res;
  logic                 out_valid_r;
  ihl_pkg::ihl_result_t out_res_r;
  logic                 advance;

  // Advance the held character when the result register is free or draining.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  ihl_parse #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parse (
    .state_i     (state_r),
    .character_i (in_char_r),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r <= in_ch.character;
    end
  end

  // Parser state: update only when the held character is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: ihl_pkg::PH_LINE_START, default: '0};
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_res_r.kind;
  assign out_ch.write_address = out_res_r.write_address;
  assign out_ch.write_data    = out_res_r.write_data;
  assign out_ch.load_end      = out_res_r.load_end;
  assign out_ch.record_type   = out_res_r.record_type;

endmodule
